// File: rtl/etb_pkg.sv
// Shared types and constants of the event trigger table.
package etb_pkg;

	localparam int ENTRIES   = 64;
	localparam int NAME_BITS = 32;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int SLOT_W    = 6;
	localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int COND_W    = 15;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_REG    = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_LOOKUP = 3'd3;
	localparam logic [2:0] OP_QUERY  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [COND_W-1:0] COND_SKIP_A   = COND_W'(16'h0011);
	localparam logic [COND_W-1:0] COND_SKIP_B   = COND_W'(16'h0012);
	localparam logic [COND_W-1:0] COND_SKIP_C   = COND_W'(16'h0013);
	localparam logic [COND_W-1:0] COND_REQUIRED = COND_W'(16'h000F);

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] cond_id;
		logic [31:0] name_tag;
		logic [5:0]  slot_in;
		logic        need_cond_f;
		logic        in_battle;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] slot_out;
	} rsp_t;

	// Operation travelling down the cell chain
	typedef struct packed {
		logic                 active;
		logic [2:0]           op;
		logic [COND_W-1:0]    cond;
		logic [NAME_BITS-1:0] tag;
		logic [SLOT_W-1:0]    slot;
		logic                 need_f;
		logic                 battle;
		logic                 hit;
		logic [IDX_W-1:0]     idx;
	} token_t;

endpackage

// File: rtl/etb_req_if.sv
// Request channel: valid/ready handshake carrying one operation.
interface etb_req_if;
	import etb_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/etb_rsp_if.sv
// Response channel: valid/ready handshake carrying one result.
interface etb_rsp_if;
	import etb_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/etb_cell.sv
// One table slot: holds its entry and acts on the passing token.
module etb_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [etb_pkg::IDX_W-1:0] my_idx,
	input  etb_pkg::token_t           tok_i,
	output etb_pkg::token_t           tok_o
);
	import etb_pkg::*;

	logic                 valid_q;
	logic [COND_W-1:0]    cond_q;
	logic [NAME_BITS-1:0] name_q;
	logic                 active_q;
	token_t               tok_q;
	token_t               tok_nxt;
	logic                 mine;
	logic                 eligible;
	logic                 take_reg;

	assign mine     = CMP_W'(tok_i.slot) == CMP_W'(my_idx);
	assign eligible = (cond_q != COND_SKIP_A) && (cond_q != COND_SKIP_B) &&
	                  (cond_q != COND_SKIP_C) &&
	                  (!tok_i.need_f || (cond_q == COND_REQUIRED));
	assign take_reg = tok_i.active && (tok_i.op == OP_REG) && !tok_i.hit && !valid_q;

	always_comb begin
		tok_nxt = tok_i;
		case (tok_i.op)
			OP_REG: begin
				if (!tok_i.hit && !valid_q) begin
					tok_nxt.hit = 1'b1;
					tok_nxt.idx = my_idx;
				end
			end
			OP_LOOKUP: begin
				if (!tok_i.battle && !tok_i.hit && valid_q && eligible &&
				    (name_q == tok_i.tag)) begin
					tok_nxt.hit = 1'b1;
					tok_nxt.idx = my_idx;
				end
			end
			OP_QUERY: begin
				if (mine && valid_q) begin
					tok_nxt.hit = 1'b1;
					tok_nxt.idx = my_idx;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			active_q <= 1'b0;
		end else begin
			active_q <= tok_i.active;
			if (tok_i.active) begin
				case (tok_i.op)
					OP_CLEAR: valid_q <= 1'b0;
					OP_REG: begin
						if (take_reg) valid_q <= 1'b1;
					end
					OP_DELETE: begin
						if (mine) valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (take_reg) begin
			cond_q <= tok_i.cond;
			name_q <= tok_i.tag;
		end
	end

	always_comb begin
		tok_o        = tok_q;
		tok_o.active = active_q;
	end

endmodule

// File: rtl/event_trigger_table_top.sv
// Event trigger table: chain of slot cells, one operation in flight at a time.
// A request's token walks every cell, then its result passes the pend and out registers.
// A new request is not taken until the previous result has left the pend register.
// A new request is taken while an earlier response still waits at the output.
// Reset (arst_n low, asynchronous) frees every slot and empties the pipeline.
module event_trigger_table_top (
	input logic clk,
	input logic arst_n,
	etb_req_if.sink   req,
	etb_rsp_if.source rsp
);
	import etb_pkg::*;

	token_t tok [ENTRIES+1];
	logic   accept;
	logic   busy_q;
	logic   pend_valid_q;
	rsp_t   pend_q;
	logic   out_valid_q;
	rsp_t   out_q;
	logic   move;
	rsp_t   res;
	token_t last;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;

	always_comb begin
		tok[0].active = accept;
		tok[0].op     = req.data.op;
		tok[0].cond   = req.data.cond_id[COND_W-1:0];
		tok[0].tag    = NAME_BITS'(req.data.name_tag);
		tok[0].slot   = req.data.slot_in;
		tok[0].need_f = req.data.need_cond_f;
		tok[0].battle = req.data.in_battle;
		tok[0].hit    = 1'b0;
		tok[0].idx    = '0;
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		etb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (IDX_W'(g)),
			.tok_i  (tok[g]),
			.tok_o  (tok[g+1])
		);
	end

	assign last = tok[ENTRIES];

	always_comb begin
		res.status   = ST_MISS;
		res.slot_out = '0;
		case (last.op)
			OP_CLEAR: res.status = ST_OK;
			OP_REG: begin
				if (last.hit) begin
					res.status   = ST_OK;
					res.slot_out = SLOT_W'(last.idx);
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_DELETE: begin
				if ((CMP_W+1)'(last.slot) < (CMP_W+1)'(ENTRIES)) res.status = ST_OK;
			end
			OP_LOOKUP, OP_QUERY: begin
				if (last.hit) begin
					res.status   = ST_OK;
					res.slot_out = SLOT_W'(last.idx);
				end
			end
			default: ;
		endcase
	end

	assign move = pend_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) busy_q <= 1'b1;
			else if (move) busy_q <= 1'b0;
			if (last.active) pend_valid_q <= 1'b1;
			else if (move) pend_valid_q <= 1'b0;
			if (move) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last.active) pend_q <= res;
		if (move) out_q <= pend_q;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule
